// ===== src/ssrch_pkg.sv =====
package ssrch_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int INDEX_BITS_DEF  = 16;
    localparam int REG_BYTES       = 16;
    localparam int POS_W           = 16;
    localparam int LEN_W           = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    typedef logic [7:0] t_byte;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO      = 3'd0,
        CFG_PAT_HI      = 3'd1,
        CFG_PAT_LEN     = 3'd2,
        CFG_IGNORE_CASE = 3'd3,
        CFG_FIND_LAST   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic ok;
        logic last;
        logic nzero;
        logic find_last;
        logic ovf;
    } t_s1_flags;

    function automatic t_byte fold_byte(t_byte c, logic en);
        t_byte r;
        r = c;
        if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== src/substring_search.sv =====
// Pipeline: 2 register stages: stage 1, then the output register once it is free.
// Throughput: 1 text byte per cycle while ready; the window cells shift and compare every byte.
// Output register decouples the sides; a new text streams while a result waits,
// holding only at its final byte until the waiting result transfers.
// Reset: synchronous, active low; clears config, window, counters, stage-1 flags and result valid.
// Configuration port is always ready and takes effect from the next text byte.
module substring_search
    import ssrch_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_last_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_found,
    output logic [POS_W-1:0]      o_match_position,
    output logic                  o_overflow
);

    localparam int CAP_INT = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam logic [LEN_W-1:0] CAP = LEN_W'(CAP_INT);
    localparam int CW = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;

    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [LEN_W-1:0]      r_pat_len;
    logic                  r_ignore_case;
    logic                  r_find_last;

    t_byte                 w_pat [REG_BYTES];
    logic [LEN_W-1:0]      w_n;

    logic [INDEX_BITS-1:0] r_count;
    logic                  r_ovf;
    logic [INDEX_BITS-1:0] w_count_inc;
    logic                  w_at_limit;
    logic                  w_len_ok;

    logic                  r_s1_valid;
    t_s1_flags             r_s1_flags;
    logic [INDEX_BITS-1:0] r_s1_pos;
    logic [INDEX_BITS-1:0] r_s1_count;
    logic                  w_out_free;
    logic                  w_s1_go;
    logic                  w_accept;

    t_byte                 w_chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] w_eq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo      <= '0;
            r_pat_hi      <= '0;
            r_pat_len     <= '0;
            r_ignore_case <= 1'b0;
            r_find_last   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PAT_LO:      r_pat_lo      <= i_cfg_data;
                CFG_PAT_HI:      r_pat_hi      <= i_cfg_data;
                CFG_PAT_LEN:     r_pat_len     <= i_cfg_data[LEN_W-1:0];
                CFG_IGNORE_CASE: r_ignore_case <= i_cfg_data[0];
                CFG_FIND_LAST:   r_find_last   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < REG_BYTES; k++) begin : g_pat
        if (k < 8) begin : g_lo
            assign w_pat[k] = r_pat_lo[8*k +: 8];
        end else begin : g_hi
            assign w_pat[k] = r_pat_hi[8*(k-8) +: 8];
        end
    end

    assign w_n = (r_pat_len > CAP) ? CAP : r_pat_len;

    assign w_out_free = !o_out_valid || i_out_ready;
    assign w_s1_go    = r_s1_valid && (!r_s1_flags.last || w_out_free);
    assign o_in_ready = !r_s1_valid || w_s1_go;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_at_limit  = &r_count;
    assign w_count_inc = r_count + 1'b1;
    assign w_len_ok    = (w_n != '0) && (CW'(w_count_inc) >= CW'(w_n));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s1_flags <= '0;
        end else begin
            if (w_accept) begin
                r_s1_valid           <= 1'b1;
                r_s1_flags.last      <= i_last_byte;
                r_s1_flags.nzero     <= (w_n == '0);
                r_s1_flags.find_last <= r_find_last;
                r_s1_flags.ok        <= !w_at_limit && w_len_ok;
                r_s1_flags.ovf       <= r_ovf || w_at_limit;
                if (i_last_byte) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else if (w_at_limit) begin
                    r_ovf   <= 1'b1;
                end else begin
                    r_count <= w_count_inc;
                end
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pos   <= w_count_inc - INDEX_BITS'(w_n);
            r_s1_count <= w_at_limit ? r_count : w_count_inc;
        end
    end

    assign w_chain[0] = i_text_byte;

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        localparam logic [6:0] J = 7'(j);
        logic       w_active;
        logic [6:0] w_idx;

        assign w_active = ({2'b00, w_n} > J);
        assign w_idx    = {2'b00, w_n} - 7'd1 - J;

        ssrch_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (w_accept),
            .i_byte     (w_chain[j]),
            .i_pat_byte (w_pat[w_idx[3:0]]),
            .i_active   (w_active),
            .i_fold     (r_ignore_case),
            .o_byte     (w_chain[j+1]),
            .o_eq       (w_eq[j])
        );
    end

    ssrch_track #(
        .MAX_PATTERN (MAX_PATTERN),
        .INDEX_BITS  (INDEX_BITS)
    ) u_track (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_go             (w_s1_go),
        .i_flags          (r_s1_flags),
        .i_pos            (r_s1_pos),
        .i_count          (r_s1_count),
        .i_eq             (w_eq),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_found          (o_found),
        .o_match_position (o_match_position),
        .o_overflow       (o_overflow)
    );

endmodule

// ===== src/ssrch_cell.sv =====
module ssrch_cell
    import ssrch_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_byte i_byte,
    input  t_byte i_pat_byte,
    input  logic  i_active,
    input  logic  i_fold,
    output t_byte o_byte,
    output logic  o_eq
);

    t_byte r_byte;
    logic  r_eq;
    logic  n_eq;

    assign n_eq = !i_active || (fold_byte(i_byte, i_fold) == fold_byte(i_pat_byte, i_fold));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
            r_eq   <= 1'b0;
        end else if (i_shift) begin
            r_byte <= i_byte;
            r_eq   <= n_eq;
        end
    end

    assign o_byte = r_byte;
    assign o_eq   = r_eq;

endmodule

// ===== src/ssrch_track.sv =====
module ssrch_track
    import ssrch_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    input  t_s1_flags              i_flags,
    input  logic [INDEX_BITS-1:0]  i_pos,
    input  logic [INDEX_BITS-1:0]  i_count,
    input  logic [MAX_PATTERN-1:0] i_eq,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_found,
    output logic [POS_W-1:0]       o_match_position,
    output logic                   o_overflow
);

    logic                  r_have;
    logic [INDEX_BITS-1:0] r_best;
    logic                  n_have;
    logic [INDEX_BITS-1:0] n_best;
    logic                  w_match;
    logic [INDEX_BITS-1:0] w_pos;

    logic                  r_out_valid;
    logic                  r_found;
    logic [POS_W-1:0]      r_position;
    logic                  r_overflow;
    logic [POS_W-1:0]      w_pos_out;

    assign w_match = i_flags.ok && (&i_eq);

    always_comb begin
        n_have = r_have;
        n_best = r_best;
        if (w_match && (i_flags.find_last || !r_have)) begin
            n_have = 1'b1;
            n_best = i_pos;
        end
    end

    always_comb begin
        w_pos = '0;
        if (i_flags.nzero) begin
            w_pos = i_flags.find_last ? i_count : '0;
        end else if (n_have) begin
            w_pos = n_best;
        end
    end

    if (INDEX_BITS >= POS_W) begin : g_trunc
        assign w_pos_out = w_pos[POS_W-1:0];
    end else begin : g_ext
        assign w_pos_out = {{(POS_W-INDEX_BITS){1'b0}}, w_pos};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_best <= '0;
        end else if (i_go) begin
            if (i_flags.last) begin
                r_have <= 1'b0;
                r_best <= '0;
            end else begin
                r_have <= n_have;
                r_best <= n_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_go && i_flags.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && i_flags.last) begin
            r_found    <= i_flags.nzero || n_have;
            r_position <= w_pos_out;
            r_overflow <= i_flags.ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_found;
    assign o_match_position = r_position;
    assign o_overflow       = r_overflow;

endmodule

// ===== src/ssrch_chk.sv =====
module ssrch_chk
    import ssrch_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic             o_found,
    input logic [POS_W-1:0] o_match_position,
    input logic             o_overflow
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_found) && $stable(o_match_position) && $stable(o_overflow))
        else $error("stalled result changed");

    a_nofind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_match_position == '0)
        else $error("position nonzero without a match");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind substring_search ssrch_chk u_ssrch_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_found          (o_found),
    .o_match_position (o_match_position),
    .o_overflow       (o_overflow)
);

// ===== tb/sv/substring_search_tb.sv =====
module substring_search_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssrch_pkg::*;

    localparam int PAT_CAP     = (MAX_PATTERN_DEF < REG_BYTES) ? MAX_PATTERN_DEF : REG_BYTES;
    localparam int IDX_LIMIT   = (1 << INDEX_BITS_DEF) - 1;
    localparam int CYCLE_LIMIT = 200_000;
    localparam logic [63:0] ONES = '1;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
        logic             ovf;
    } search_result_t;

    typedef struct packed {
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [4:0]       len;
        logic             nocase;
        logic             back;
        logic [31:0]      txt;
        logic [2:0]       nb;
        logic             typed;
        logic             e_found;
        logic [POS_W-1:0] e_pos;
        logic             e_ovf;
    } dir_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_PAT_LO;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_text_byte = '0;
    logic                  i_last_byte = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_found;
    logic [POS_W-1:0]      o_match_position;
    logic                  o_overflow;

    // configuration mirror
    logic [63:0] pat_lo, pat_hi;
    logic [4:0]  pat_len;
    logic        fold_case, last_mode;

    // stream state mirror
    t_byte       win [MAX_PATTERN_DEF];
    logic [16:0] seen_count;
    logic        hit;
    logic [15:0] best_pos;
    logic        ran_over;

    search_result_t pending_results [$];
    search_result_t want;
    search_result_t typed_res;
    logic           typed_pending = 1'b0;
    t_byte          text_q [$];
    dir_row_t       dir_tab [10];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int n_errors = 0;
    int n_checked = 0;
    int n_texts = 0;
    int n_bytes = 0;
    int cycle_count = 0;
    int goal;

    substring_search DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_text_byte     (i_text_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_match_position(o_match_position),
        .o_overflow      (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic t_byte fold_ascii(t_byte c);
        t_byte r;
        r = c;
        if (fold_case && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic t_byte pattern_at(int k);
        t_byte r;
        if (k < 8) begin
            r = pat_lo[8*k +: 8];
        end else begin
            r = pat_hi[8*(k-8) +: 8];
        end
        return r;
    endfunction

    function automatic t_byte pick_byte();
        t_byte c;
        case ($urandom_range(9))
            0, 1: c = t_byte'($urandom_range(255));
            2, 3, 4: c = 8'h61;
            5, 6: c = 8'h62;
            7: c = 8'h41;
            default: c = 8'h42;
        endcase
        return c;
    endfunction

    task automatic search_step(input t_byte b, input logic lst);
        int n;
        logic eq;
        search_result_t r;
        n = (pat_len > PAT_CAP) ? PAT_CAP : pat_len;
        for (int k = MAX_PATTERN_DEF - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = b;
        if (seen_count >= IDX_LIMIT) begin
            ran_over = 1'b1;
        end else begin
            seen_count = seen_count + 1'b1;
            if (n > 0 && seen_count >= n) begin
                eq = 1'b1;
                for (int k = 0; k < n; k++) begin
                    if (fold_ascii(win[n-1-k]) != fold_ascii(pattern_at(k))) eq = 1'b0;
                end
                if (eq && (last_mode || !hit)) begin
                    hit = 1'b1;
                    best_pos = 16'(seen_count - n);
                end
            end
        end
        if (lst) begin
            r.found = (n == 0) || hit;
            if (n == 0) begin
                r.pos = last_mode ? seen_count[POS_W-1:0] : '0;
            end else begin
                r.pos = hit ? best_pos : '0;
            end
            r.ovf = ran_over;
            if (typed_pending) r = typed_res;
            typed_pending = 1'b0;
            pending_results.push_back(r);
            foreach (win[k]) win[k] = '0;
            seen_count = '0;
            hit = 1'b0;
            best_pos = '0;
            ran_over = 1'b0;
            n_texts++;
        end
    endtask

    task automatic send_byte(input t_byte b, input logic lst);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= b;
        i_last_byte <= lst;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_bytes++;
        search_step(b, lst);
    endtask

    task automatic cfg_put(input t_cfg_idx idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_PAT_LO:      pat_lo = val;
            CFG_PAT_HI:      pat_hi = val;
            CFG_PAT_LEN:     pat_len = val[4:0];
            CFG_IGNORE_CASE: fold_case = val[0];
            CFG_FIND_LAST:   last_mode = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [4:0] len, input logic nocase, input logic back);
        cfg_put(CFG_PAT_LO, lo);
        cfg_put(CFG_PAT_HI, hi);
        cfg_put(CFG_PAT_LEN, 64'(len));
        cfg_put(CFG_IGNORE_CASE, 64'(nocase));
        cfg_put(CFG_FIND_LAST, 64'(back));
        i_cfg_valid <= 1'b0;
    endtask

    // hold off until every result has come and the pipeline is empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_config(input int want_len);
        logic [63:0] lo, hi;
        int len;
        for (int k = 0; k < 8; k++) begin
            lo[8*k +: 8] = pick_byte();
            hi[8*k +: 8] = pick_byte();
        end
        case ($urandom_range(19))
            0: lo = '0;
            1: lo = ONES;
            2: hi = '0;
            3: hi = ONES;
            default: ;
        endcase
        if (want_len >= 0) begin
            len = want_len;
        end else begin
            case ($urandom_range(19))
                0: len = 0;
                1: len = PAT_CAP;
                2: len = $urandom_range(31, 17);
                3, 4: len = $urandom_range(15, 5);
                default: len = $urandom_range(4, 1);
            endcase
        end
        apply_config(lo, hi, 5'(len), 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // random text with planted copies of the pattern, some cut short
    task automatic build_text();
        int n, len, at, m;
        t_byte c;
        text_q.delete();
        n = (pat_len > PAT_CAP) ? PAT_CAP : pat_len;
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(40, 17);
        end else begin
            len = $urandom_range(12, 1) + ($urandom_range(1) ? n : 0);
        end
        for (int k = 0; k < len; k++) text_q.push_back(pick_byte());
        if (n > 0 && len >= n && $urandom_range(3) != 0) begin
            repeat ($urandom_range(2, 1)) begin
                at = $urandom_range(len - n);
                m = ($urandom_range(4) == 0) ? $urandom_range(n - 1, 0) : n;
                for (int k = 0; k < m; k++) begin
                    c = pattern_at(k);
                    if (fold_case && $urandom_range(1) && (c | 8'h20) >= 8'h61
                            && (c | 8'h20) <= 8'h7A) begin
                        c = c ^ 8'h20;
                    end
                    text_q[at + k] = c;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result found=%0b position=%0d overflow=%0b",
                         $time, o_found, o_match_position, o_overflow);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found) begin
                    $display("%0t: found expected %0b actual %0b", $time, want.found, o_found);
                    n_errors++;
                end
                if (o_match_position !== want.pos) begin
                    $display("%0t: match_position expected %0d actual %0d",
                             $time, want.pos, o_match_position);
                    n_errors++;
                end
                if (o_overflow !== want.ovf) begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, want.ovf, o_overflow);
                    n_errors++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    initial begin
        pat_lo = '0;
        pat_hi = '0;
        pat_len = '0;
        fold_case = 1'b0;
        last_mode = 1'b0;
        foreach (win[k]) win[k] = '0;
        seen_count = '0;
        hit = 1'b0;
        best_pos = '0;
        ran_over = 1'b0;

        dir_tab = '{
            '{64'h0, 64'h0, 5'd0, 1'b0, 1'b0, 32'h0000_0078, 3'd1, 1'b1, 1'b1, 16'd0, 1'b0},
            '{64'h0, ONES, 5'd0, 1'b0, 1'b1, 32'h0041_FF00, 3'd3, 1'b1, 1'b1, 16'd3, 1'b0},
            '{64'h6261, 64'h0, 5'd2, 1'b0, 1'b0, 32'h0000_0061, 3'd1, 1'b1, 1'b0, 16'd0, 1'b0},
            '{64'h6261, 64'h0, 5'd2, 1'b0, 1'b0, 32'h6261_6261, 3'd4, 1'b1, 1'b1, 16'd0, 1'b0},
            '{64'h6261, 64'h0, 5'd2, 1'b0, 1'b1, 32'h6261_6261, 3'd4, 1'b1, 1'b1, 16'd2, 1'b0},
            '{64'h4241, 64'h0, 5'd2, 1'b1, 1'b0, 32'h0062_6178, 3'd3, 1'b0, 1'b0, 16'd0, 1'b0},
            '{64'h4241, 64'h0, 5'd2, 1'b0, 1'b0, 32'h0000_6261, 3'd2, 1'b1, 1'b0, 16'd0, 1'b0},
            '{64'h00FF, 64'h0, 5'd2, 1'b0, 1'b0, 32'h0000_00FF, 3'd2, 1'b1, 1'b1, 16'd0, 1'b0},
            '{ONES, ONES, 5'd31, 1'b0, 1'b0, 32'h0000_FFFF, 3'd2, 1'b1, 1'b0, 16'd0, 1'b0},
            '{64'h005B, 64'h0, 5'd1, 1'b1, 1'b0, 32'h0000_007B, 3'd1, 1'b0, 1'b0, 16'd0, 1'b0}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 6;
        rcv_idle_pct = 57;
        foreach (dir_tab[r]) begin
            settle();
            apply_config(dir_tab[r].lo, dir_tab[r].hi, dir_tab[r].len,
                         dir_tab[r].nocase, dir_tab[r].back);
            typed_pending = dir_tab[r].typed;
            typed_res = '{dir_tab[r].e_found, dir_tab[r].e_pos, dir_tab[r].e_ovf};
            for (int k = 0; k < dir_tab[r].nb; k++) begin
                send_byte(dir_tab[r].txt[8*k +: 8], k == dir_tab[r].nb - 1);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            settle();
            snd_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 57 : 0;
            rcv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 6 : 0;
            random_config((ph == 0) ? PAT_CAP : (ph == 1) ? 31 : -1);
            goal = n_bytes + 500;
            while (n_bytes < goal) begin
                if ($urandom_range(3) == 0) begin
                    settle();
                    random_config(-1);
                end
                build_text();
                foreach (text_q[k]) send_byte(text_q[k], k == text_q.size() - 1);
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("searched %0d texts, %0d bytes; %0d results checked, %0d mismatches",
                 n_texts, n_bytes, n_checked, n_errors);
        $display("empty, oversize and case-folded patterns in both modes under stalls");
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
